/* src/pgtk_pkg.sv */
// Shared types and constants for the per-group top-k selection block.
package pgtk_pkg;

  localparam int DEF_MAX_REGIONS = 256;
  localparam int DEF_MAX_IMAGES  = 16;
  localparam int DEF_MAX_KEEP    = 64;

  localparam int SCORE_W = 16;
  localparam int IMG_W   = 4;
  localparam int QUOTA_W = 7;
  localparam int ICNT_W  = 5;
  localparam int KEEP_W  = 7;
  localparam int PROD_W  = QUOTA_W + ICNT_W;
  localparam int INDEX_W = 8;
  localparam int FIFO_DEPTH = 4;

  localparam logic CFG_QUOTA  = 1'b0;
  localparam logic CFG_IMAGES = 1'b1;

  // word passed from front to back
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [IMG_W-1:0]          img;
    logic                      ok;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic [QUOTA_W-1:0] quota;
    logic [ICNT_W-1:0]  images;
  } cfg_t;

endpackage

/* src/pgtk_fifo.sv */
// Small queue between the front and the back.
module pgtk_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pgtk_pkg::item_t push_data,
  output logic           full,
  input  logic           pop,
  output pgtk_pkg::item_t pop_data,
  output logic           empty
);

  localparam int PW = $clog2(pgtk_pkg::FIFO_DEPTH);

  pgtk_pkg::item_t mem [pgtk_pkg::FIFO_DEPTH];
  logic [PW:0] wr_ptr_r, rd_ptr_r;

  assign empty    = (wr_ptr_r == rd_ptr_r);
  assign full     = (wr_ptr_r[PW-1:0] == rd_ptr_r[PW-1:0]) && (wr_ptr_r[PW] != rd_ptr_r[PW]);
  assign pop_data = mem[rd_ptr_r[PW-1:0]];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r[PW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

endmodule

/* src/pgtk_front.sv */
// Front: config registers, image id check and push into the queue.
module pgtk_front #(
  parameter int MAX_IMAGES = pgtk_pkg::DEF_MAX_IMAGES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [pgtk_pkg::QUOTA_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [pgtk_pkg::SCORE_W-1:0] in_score,
  input  logic [pgtk_pkg::IMG_W-1:0]  in_img,
  input  logic                        in_last_region,
  output logic                        push,
  output pgtk_pkg::item_t             push_data,
  input  logic                        full,
  output pgtk_pkg::cfg_t              cfg
);

  logic [pgtk_pkg::QUOTA_W-1:0] quota_r;
  logic [pgtk_pkg::ICNT_W-1:0]  icnt_r;
  logic [pgtk_pkg::ICNT_W-1:0]  images;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quota_r <= pgtk_pkg::QUOTA_W'(16);
      icnt_r  <= pgtk_pkg::ICNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgtk_pkg::CFG_QUOTA:  quota_r <= cfg_wdata;
        pgtk_pkg::CFG_IMAGES: icnt_r  <= cfg_wdata[pgtk_pkg::ICNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the supported image count
  assign images = (int'(icnt_r) > MAX_IMAGES) ? pgtk_pkg::ICNT_W'(MAX_IMAGES) : icnt_r;

  assign cfg.quota  = quota_r;
  assign cfg.images = images;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  assign push_data.score = in_score;
  assign push_data.img   = in_img;
  assign push_data.ok    = {1'b0, in_img} < images;
  assign push_data.last  = in_last_region;

endmodule

/* src/pgtk_back.sv */
// Back: region store, two ranking passes and the result register.
module pgtk_back #(
  parameter int MAX_REGIONS = pgtk_pkg::DEF_MAX_REGIONS,
  parameter int MAX_KEEP    = pgtk_pkg::DEF_MAX_KEEP
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pgtk_pkg::cfg_t      cfg,
  input  logic                empty,
  input  pgtk_pkg::item_t     pop_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [pgtk_pkg::INDEX_W-1:0] out_kept_index,
  output logic                out_last_kept,
  output logic                out_bad_image_seen
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int EW = pgtk_pkg::SCORE_W + pgtk_pkg::IMG_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_RDI   = 3'd2;
  localparam logic [2:0] S_LDI   = 3'd3;
  localparam logic [2:0] S_RDJ   = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_END   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // entry: {first-pass pick, image id, score}
  logic [EW-1:0] mem [MAX_REGIONS];
  logic [EW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt;
  logic          pass2_r, pass2_nxt;
  logic          bad_r, bad_nxt;
  logic [pgtk_pkg::KEEP_W-1:0] batch_r, batch_nxt, emit_r, emit_nxt;
  logic [pgtk_pkg::PROD_W-1:0] prod_r;
  logic signed [pgtk_pkg::SCORE_W-1:0] cur_score_r, cur_score_nxt;
  logic [pgtk_pkg::IMG_W-1:0] cur_img_r, cur_img_nxt;
  logic          cur_fp_r, cur_fp_nxt;
  logic          ov_r, ov_nxt, ol_r, ol_nxt, ob_r, ob_nxt;
  logic [pgtk_pkg::INDEX_W-1:0] oi_r, oi_nxt;

  logic signed [pgtk_pkg::SCORE_W-1:0] sj;
  logic [pgtk_pkg::IMG_W-1:0] imgj;
  logic          fpj, beats, beats_key, hit, store_ok, last_i, keep;
  logic [15:0]   bmin;

  assign sj   = rd_data_r[pgtk_pkg::SCORE_W-1:0];
  assign imgj = rd_data_r[pgtk_pkg::SCORE_W +: pgtk_pkg::IMG_W];
  assign fpj  = rd_data_r[EW-1];

  assign beats     = (sj > cur_score_r) || ((sj == cur_score_r) && (j_r > i_r));
  assign beats_key = (fpj != cur_fp_r) ? fpj : beats;
  assign hit       = (j_r != i_r) && (pass2_r ? beats_key : ((imgj == cur_img_r) && beats));
  assign store_ok  = pop_data.ok && (count_r != CW'(MAX_REGIONS));
  assign last_i    = (i_r + 1'b1) == count_r;
  assign keep      = 16'(rank_r) < 16'(batch_r);

  assign pop     = (state_r == S_IDLE) && !empty;
  assign rd_addr = (state_r == S_RDI) ? i_r[AW-1:0] : j_r[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = {1'b0, pop_data.img, pop_data.score};
    if (pop && store_ok) begin
      wr_en = 1'b1;
    end else if (state_r == S_END && !pass2_r) begin
      wr_en   = 1'b1;
      wr_addr = i_r[AW-1:0];
      wr_data = {16'(rank_r) < 16'(cfg.quota), cur_img_r, cur_score_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
    prod_r    <= cfg.images * cfg.quota;
  end

  always_comb begin
    bmin = 16'(prod_r);
    if (16'(count_r) < bmin) bmin = 16'(count_r);
    if (16'(MAX_KEEP) < bmin) bmin = 16'(MAX_KEEP);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rank_nxt      = rank_r;
    pass2_nxt     = pass2_r;
    bad_nxt       = bad_r;
    batch_nxt     = batch_r;
    emit_nxt      = emit_r;
    cur_score_nxt = cur_score_r;
    cur_img_nxt   = cur_img_r;
    cur_fp_nxt    = cur_fp_r;
    ov_nxt        = ov_r;
    oi_nxt        = oi_r;
    ol_nxt        = ol_r;
    ob_nxt        = ob_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          if (store_ok) count_nxt = count_r + 1'b1;
          if (!pop_data.ok) bad_nxt = 1'b1;
          if (pop_data.last) state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        batch_nxt = pgtk_pkg::KEEP_W'(bmin);
        i_nxt     = '0;
        pass2_nxt = 1'b0;
        emit_nxt  = '0;
        if (bmin == 16'd0) begin
          count_nxt = '0;
          bad_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RDI;
        end
      end
      S_RDI: state_nxt = S_LDI;
      S_LDI: begin
        cur_score_nxt = sj;
        cur_img_nxt   = imgj;
        cur_fp_nxt    = fpj;
        j_nxt         = '0;
        rank_nxt      = '0;
        state_nxt     = S_RDJ;
      end
      S_RDJ: state_nxt = S_CMP;
      S_CMP: begin
        if (hit) rank_nxt = rank_r + 1'b1;
        j_nxt = j_r + 1'b1;
        state_nxt = ((j_r + 1'b1) == count_r) ? S_END : S_RDJ;
      end
      S_END, S_OUT: begin
        if (state_r == S_END && pass2_r && keep) begin
          ov_nxt    = 1'b1;
          oi_nxt    = pgtk_pkg::INDEX_W'(i_r);
          ol_nxt    = (emit_r + 1'b1) == batch_r;
          ob_nxt    = bad_r;
          emit_nxt  = emit_r + 1'b1;
          state_nxt = S_OUT;
        end else if (state_r == S_END || out_ready) begin
          if (state_r == S_OUT) ov_nxt = 1'b0;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RDI;
          if (last_i) begin
            i_nxt = '0;
            if (pass2_r) begin
              count_nxt = '0;
              bad_nxt   = 1'b0;
              state_nxt = S_IDLE;
            end else begin
              pass2_nxt = 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      bad_r   <= 1'b0;
      ov_r    <= 1'b0;
      pass2_r <= 1'b0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bad_r   <= bad_nxt;
      ov_r    <= ov_nxt;
      pass2_r <= pass2_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    rank_r      <= rank_nxt;
    batch_r     <= batch_nxt;
    cur_score_r <= cur_score_nxt;
    cur_img_r   <= cur_img_nxt;
    cur_fp_r    <= cur_fp_nxt;
    oi_r        <= oi_nxt;
    ol_r        <= ol_nxt;
    ob_r        <= ob_nxt;
  end

  assign out_valid          = ov_r;
  assign out_kept_index     = oi_r;
  assign out_last_kept      = ol_r;
  assign out_bad_image_seen = ob_r;

`ifndef SYNTHESIS
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (state_r == S_OUT)) else $error("result valid outside emit state");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_REGIONS)) else $error("region count overflow");
  a_emit_le_batch: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (emit_r <= batch_r)) else $error("more results than batch");
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (j_r < count_r && i_r < count_r)) else $error("scan out of range");
`endif

endmodule

/* src/per_group_top_k_hard_mining_core.sv */
// Top level of the per-group top-k selection block.
//
//  port group  | dir | handshake        | word
//  in_*        | in  | in_valid/in_ready| score, img, last_region
//  out_*       | out | out_valid/ready  | kept_index, last_kept, bad_image_seen
//  cfg_*       | in  | cfg_we           | index 0 quota, 1 image count
//
// Loading takes one word per cycle through a 4-word queue whenever the queue has room.
// Selection runs after the last word: two ranking passes over n stored regions,
// both through the store's one read port, with each kept result emitted during
// the second pass; a set whose batch works out empty skips both passes.
// Each kept result waits in the output register until taken; the walk stalls there.
// The queue keeps accepting words during selection until it fills.
// rst_n is synchronous; it clears count, flag and control, not the store.
module per_group_top_k_hard_mining_core #(
  parameter int MAX_REGIONS = pgtk_pkg::DEF_MAX_REGIONS,
  parameter int MAX_IMAGES  = pgtk_pkg::DEF_MAX_IMAGES,
  parameter int MAX_KEEP    = pgtk_pkg::DEF_MAX_KEEP
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [pgtk_pkg::QUOTA_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [pgtk_pkg::SCORE_W-1:0] in_score,
  input  logic [pgtk_pkg::IMG_W-1:0]  in_img,
  input  logic                        in_last_region,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pgtk_pkg::INDEX_W-1:0] out_kept_index,
  output logic                        out_last_kept,
  output logic                        out_bad_image_seen
);

  logic            push, full, pop, empty;
  pgtk_pkg::item_t push_data, pop_data;
  pgtk_pkg::cfg_t  cfg;

  pgtk_front #(.MAX_IMAGES(MAX_IMAGES)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_score, .in_img, .in_last_region,
    .push, .push_data, .full, .cfg
  );

  pgtk_fifo u_fifo (
    .clk, .rst_n, .push, .push_data, .full, .pop, .pop_data, .empty
  );

  pgtk_back #(.MAX_REGIONS(MAX_REGIONS), .MAX_KEEP(MAX_KEEP)) u_back (
    .clk, .rst_n, .cfg, .empty, .pop_data, .pop,
    .out_valid, .out_ready, .out_kept_index, .out_last_kept, .out_bad_image_seen
  );

endmodule

/* tb/sv/tb.sv */
// Testbench for the per-group top-k hard mining core: directed and random region sets.
`timescale 1ns / 1ps

module tb;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  STORE_DEPTH  = 256;
  localparam int  IMG_LIMIT    = 16;
  localparam int  KEEP_LIMIT   = 64;

  typedef struct packed {
    logic [pgtk_pkg::INDEX_W-1:0] index;
    logic                         last;
    logic                         bad;
  } kept_t;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic                                cfg_index;
  logic [pgtk_pkg::QUOTA_W-1:0]        cfg_wdata;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [pgtk_pkg::SCORE_W-1:0] in_score;
  logic [pgtk_pkg::IMG_W-1:0]          in_img;
  logic                                in_last_region;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [pgtk_pkg::INDEX_W-1:0]        out_kept_index;
  logic                                out_last_kept;
  logic                                out_bad_image_seen;

  per_group_top_k_hard_mining_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_score(in_score),
    .in_img(in_img), .in_last_region(in_last_region),
    .out_valid(out_valid), .out_ready(out_ready), .out_kept_index(out_kept_index),
    .out_last_kept(out_last_kept), .out_bad_image_seen(out_bad_image_seen)
  );

  // predictor state
  logic signed [pgtk_pkg::SCORE_W-1:0] score_mem [STORE_DEPTH];
  logic [pgtk_pkg::IMG_W-1:0]          image_mem [STORE_DEPTH];
  bit                                  first_pick [STORE_DEPTH];
  int                                  stored;
  bit                                  bad_seen;
  int                                  quota_reg;
  int                                  images_reg;
  kept_t                               kept_q[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  mismatches = 0;
  int  words_sent;
  int  sets_sent;
  int  results_seen = 0;
  int  longest_set;
  int  cycles = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, kept_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // higher score wins, ties go to the higher position
  function automatic bit outranks(int a, int b);
    if (score_mem[a] != score_mem[b]) return score_mem[a] > score_mem[b];
    return a > b;
  endfunction

  function automatic bit outranks_key(int a, int b);
    if (first_pick[a] != first_pick[b]) return first_pick[a];
    return outranks(a, b);
  endfunction

  task automatic predict_selection();
    int imgs;
    int batch;
    int rank;
    kept_t k;
    int first_new;
    imgs = (images_reg > IMG_LIMIT) ? IMG_LIMIT : images_reg;
    batch = imgs * quota_reg;
    if (batch > stored) batch = stored;
    if (batch > KEEP_LIMIT) batch = KEEP_LIMIT;
    for (int i = 0; i < stored; i++) begin
      rank = 0;
      for (int j = 0; j < stored; j++)
        if (j != i && image_mem[j] == image_mem[i] && outranks(j, i)) rank++;
      first_pick[i] = (rank < quota_reg);
    end
    first_new = kept_q.size();
    for (int i = 0; i < stored; i++) begin
      rank = 0;
      for (int j = 0; j < stored; j++)
        if (j != i && outranks_key(j, i)) rank++;
      if (rank < batch) begin
        k.index = i[pgtk_pkg::INDEX_W-1:0];
        k.last  = 1'b0;
        k.bad   = bad_seen;
        kept_q  = {kept_q, k};
      end
    end
    if (kept_q.size() > first_new) kept_q[kept_q.size()-1].last = 1'b1;
    stored = 0;
    bad_seen = 1'b0;
  endtask

  task automatic store_region(logic signed [pgtk_pkg::SCORE_W-1:0] s,
                              logic [pgtk_pkg::IMG_W-1:0] id, logic lst);
    int imgs;
    imgs = (images_reg > IMG_LIMIT) ? IMG_LIMIT : images_reg;
    if (id >= imgs) bad_seen = 1'b1;
    else if (stored < STORE_DEPTH) begin
      score_mem[stored] = s;
      image_mem[stored] = id;
      stored++;
    end
    if (lst) begin
      predict_selection();
      sets_sent++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (kept_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: index %0d last %0b bad %0b",
                   out_kept_index, out_last_kept, out_bad_image_seen);
        mismatches++;
      end else begin
        kept_t e;
        e = kept_q.pop_front();
        if (out_kept_index !== e.index || out_last_kept !== e.last ||
            out_bad_image_seen !== e.bad) begin
          if (mismatches < 10)
            $display("mismatch: exp index %0d last %0b bad %0b, got %0d %0b %0b",
                     e.index, e.last, e.bad, out_kept_index, out_last_kept,
                     out_bad_image_seen);
          mismatches++;
        end
      end
    end
  end

  task automatic send_region(logic signed [pgtk_pkg::SCORE_W-1:0] s,
                             logic [pgtk_pkg::IMG_W-1:0] id, logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_score       <= s;
    in_img         <= id;
    in_last_region <= lst;
    do @(posedge clk); while (!in_ready);
    store_region(s, id, lst);
    words_sent++;
  endtask

  // wait for all results, then let a set without results finish its passes
  task automatic drain();
    in_valid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (4 * longest_set * longest_set + 8 * longest_set + 64) @(posedge clk);
    longest_set = 0;
  endtask

  task automatic write_cfg(logic idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[pgtk_pkg::QUOTA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pgtk_pkg::CFG_QUOTA) quota_reg = value & 'h7F;
    else images_reg = value & 'h1F;
  endtask

  task automatic set_config(int quota, int imgs);
    drain();
    write_cfg(pgtk_pkg::CFG_QUOTA, quota);
    write_cfg(pgtk_pkg::CFG_IMAGES, imgs);
    @(posedge clk);
  endtask

  // n regions; bad_pct chance of an arbitrary (maybe invalid) image id
  task automatic random_set(int n, int bad_pct, bit narrow);
    int imgs;
    logic [pgtk_pkg::IMG_W-1:0] id;
    logic signed [pgtk_pkg::SCORE_W-1:0] s;
    imgs = (images_reg > IMG_LIMIT) ? IMG_LIMIT : images_reg;
    if (n > longest_set) longest_set = (n > STORE_DEPTH) ? STORE_DEPTH : n;
    for (int k = 0; k < n; k++) begin
      if (imgs == 0 || $urandom_range(99) < bad_pct)
        id = pgtk_pkg::IMG_W'($urandom_range(15));
      else id = pgtk_pkg::IMG_W'($urandom_range(imgs - 1));
      if (narrow) s = $signed(16'($urandom_range(7))) - 16'sd4;
      else s = 16'($urandom);
      send_region(s, id, k == n - 1);
    end
  endtask

  task automatic test_reset_defaults();
    // quota 16, one image: extremes, ties, an invalid id and a lone-region set
    send_region(16'sh7FFF, 4'd0, 1'b0);
    send_region(-16'sh8000, 4'd0, 1'b0);
    send_region(16'sh0000, 4'd15, 1'b0);
    send_region(16'sh0000, 4'd0, 1'b0);
    send_region(16'sh0000, 4'd0, 1'b0);
    send_region(16'sh5A5A, 4'd0, 1'b0);
    send_region(-16'sh5A5B, 4'd0, 1'b0);
    send_region(16'sh7FFF, 4'd0, 1'b1);
    send_region(16'sh1234, 4'd0, 1'b1);
    longest_set = 8;
  endtask

  task automatic test_empty_batch();
    set_config(0, 4);
    random_set(5, 10, 0);
    set_config(8, 0);
    random_set(4, 0, 0);
  endtask

  task automatic test_fill_pass();
    set_config(3, 2);
    for (int k = 0; k < 8; k++) send_region(16'(k % 3), 4'd0, k == 7);
    longest_set = 8;
  endtask

  // full store; the first pass picks far more than the keep cap
  task automatic test_store_full();
    set_config(64, 16);
    random_set(258, 0, 1);
  endtask

  task automatic test_random_phase(int send_pct, int recv_pct, int quota, int imgs);
    int budget;
    bit paused;
    set_config(quota, imgs);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    budget = 16;
    paused = 0;
    while (budget > 0) begin
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      random_set(n, 12, $urandom_range(1));
      budget -= n;
      if (!paused && budget < 8) begin
        drain();
        paused = 1;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = pgtk_pkg::CFG_QUOTA;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_score       = '0;
    in_img         = '0;
    in_last_region = 1'b0;
    words_sent = 0;
    sets_sent = 0;
    longest_set = 0;
    stored = 0;
    bad_seen = 1'b0;
    quota_reg = 16;
    images_reg = 1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_empty_batch();
    test_fill_pass();
    test_store_full();
    test_random_phase(0, 0, 1, 16);
    test_random_phase(52, 0, 64, 3);
    test_random_phase(0, 52, 2, 31);
    test_random_phase(25, 25, 5, 4);

    drain();
    $display("covered %0d words in %0d sets, %0d kept results checked", words_sent,
             sets_sent, results_seen);
    $display("quota 0..127, image counts 0..31, store overflow and keep cap exercised");
    if (mismatches == 0) $display("Regression PASS");
    else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
